FILE: rtl/lud_pkg.sv
`timescale 1ns / 1ps
// lud_pkg: types, constants and byte classification for the lenient UTF-8 decoder.
// No dependencies; used by the interfaces, the front end, the back end and the top level.
package lud_pkg;

   localparam int BYTE_W    = 8;
   localparam int CP_W      = 21;
   localparam int GW_W      = 5;
   localparam int TW_W      = 16;
   localparam int NEED_W    = 2;
   localparam int CONT_BITS = 6;

   // default depth of the queue between front and back end
   localparam int QUEUE_DEPTH = 2;

   localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_TOP   = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_CODE  = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_TOP   = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_CODE  = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_TOP   = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_CODE  = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD2_BITS  = 8'h1F;
   localparam logic [BYTE_W-1:0] LEAD3_BITS  = 8'h0F;
   localparam logic [BYTE_W-1:0] LEAD4_BITS  = 8'h07;

   localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
   localparam logic [CP_W-1:0] NARROW_LIMIT   = 21'h000080;
   localparam logic [GW_W-1:0] GW_NARROW      = 5'd8;
   localparam logic [GW_W-1:0] GW_WIDE        = 5'd16;
   localparam logic [TW_W-1:0] WIDTH_MAX      = 16'hFFFF;

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_LEAD,
      KIND_BAD,
      KIND_END
   } byte_kind_type;

   typedef struct packed {
      byte_kind_type       kind;
      logic [NEED_W-1:0]   need;
      logic [BYTE_W-1:0]   data;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_head_type;

   function automatic entry_type classify(input logic [BYTE_W-1:0] b);
      entry_type e;
      e.data = b;
      e.need = '0;
      priority if (b == '0) begin
         e.kind = KIND_END;
      end else if (b < ASCII_LIMIT) begin
         e.kind = KIND_PLAIN;
      end else if ((b & LEAD2_TOP) == LEAD2_CODE) begin
         e.kind = KIND_LEAD;
         e.need = 2'd1;
      end else if ((b & LEAD3_TOP) == LEAD3_CODE) begin
         e.kind = KIND_LEAD;
         e.need = 2'd2;
      end else if ((b & LEAD4_TOP) == LEAD4_CODE) begin
         e.kind = KIND_LEAD;
         e.need = 2'd3;
      end else begin
         e.kind = KIND_BAD;
      end
      return e;
   endfunction

   // payload bits of a lead byte, by the number of following bytes it announces
   function automatic logic [CP_W-1:0] lead_bits(input logic [BYTE_W-1:0] b,
                                                 input logic [NEED_W-1:0] need);
      logic [CP_W-1:0] r;
      unique case (need)
         2'd1:    r = CP_W'(b & LEAD2_BITS);
         2'd2:    r = CP_W'(b & LEAD3_BITS);
         2'd3:    r = CP_W'(b & LEAD4_BITS);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/lud_if.sv
`timescale 1ns / 1ps
// lud_req_if / lud_rsp_if: valid/ready channels of the decoder.
// Depends on lud_pkg for the field widths.
interface lud_req_if import lud_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface lud_rsp_if import lud_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CP_W-1:0] code_point;
   logic            is_replacement;
   logic [GW_W-1:0] glyph_width;
   logic [TW_W-1:0] text_width;
   logic            end_of_text;

   modport source (output valid, output code_point, output is_replacement,
                   output glyph_width, output text_width, output end_of_text,
                   input ready);
   modport sink   (input valid, input code_point, input is_replacement,
                   input glyph_width, input text_width, input end_of_text,
                   output ready);
endinterface

FILE: rtl/lud_front.sv
`timescale 1ns / 1ps
// lud_front: takes text bytes, classifies them and queues the entries for the back end.
// Depends on lud_pkg and lud_req_if.
module lud_front import lud_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   lud_req_if.sink         req_chan,
   output queue_head_type  head,
   input  logic            pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   entry_type       slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff,  count_in;
   logic            push;

   assign req_chan.ready = (count_ff != FullCnt);
   assign push           = req_chan.valid && req_chan.ready;

   assign head.valid = (count_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= classify(req_chan.in_byte);
      end
   end

endmodule

FILE: rtl/lud_back.sv
`timescale 1ns / 1ps
// lud_back: decoder state, truncated-sequence replay and the result register.
// Depends on lud_pkg and lud_rsp_if.
module lud_back import lud_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  queue_head_type  head,
   output logic            pop,
   lud_rsp_if.source       rsp_chan
);

   typedef enum logic {
      ST_RUN,
      ST_REPLAY
   } state_type;

   state_type          state_ff,    state_in;
   logic [NEED_W-1:0]  needed_ff,   needed_in;
   logic [NEED_W-1:0]  seen_ff,     seen_in;
   logic [CP_W-1:0]    acc_ff,      acc_in;
   logic [BYTE_W-1:0]  held_ff [2];
   logic [BYTE_W-1:0]  held_in [2];
   logic [BYTE_W-1:0]  replay_ff [2];
   logic [BYTE_W-1:0]  replay_in [2];
   logic               idx_ff,      idx_in;
   logic               last_ff,     last_in;
   logic [TW_W-1:0]    wsum_ff,     wsum_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CP_W-1:0]    cp_ff,       cp_in;
   logic               rep_ff,      rep_in;
   logic [GW_W-1:0]    gw_ff,       gw_in;
   logic [TW_W-1:0]    tw_ff,       tw_in;
   logic               eot_ff,      eot_in;

   entry_type          cur;
   logic               slot_free;
   logic               step;
   logic               res_fire;
   logic [CP_W-1:0]    res_cp;
   logic               res_rep;
   logic [NEED_W-1:0]  seen_inc;
   logic [CP_W-1:0]    acc_shift;
   logic [GW_W-1:0]    gw;
   logic [TW_W:0]      sum_wide;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign cur       = (state_ff == ST_REPLAY) ? classify(replay_ff[idx_ff]) : head.entry;
   assign step      = slot_free && ((state_ff == ST_REPLAY) || head.valid);
   assign seen_inc  = seen_ff + 1'b1;
   assign acc_shift = {acc_ff[CP_W-CONT_BITS-1:0], cur.data[CONT_BITS-1:0]};

   always_comb begin
      state_in     = state_ff;
      needed_in    = needed_ff;
      seen_in      = seen_ff;
      acc_in       = acc_ff;
      held_in      = held_ff;
      replay_in    = replay_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      wsum_in      = wsum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      cp_in        = cp_ff;
      rep_in       = rep_ff;
      gw_in        = gw_ff;
      tw_in        = tw_ff;
      eot_in       = eot_ff;
      pop          = 1'b0;
      res_fire     = 1'b0;
      res_cp       = '0;
      res_rep      = 1'b0;

      if (step) begin
         if ((state_ff == ST_REPLAY) || (cur.kind != KIND_END)) begin
            if (state_ff == ST_RUN) begin
               pop = 1'b1;
            end else if (idx_ff == last_ff) begin
               state_in = ST_RUN;
            end else begin
               idx_in = 1'b1;
            end

            if (needed_ff != '0) begin
               // any nonzero byte inside an open sequence counts as a following byte
               acc_in = acc_shift;
               if (!seen_ff[1]) begin
                  held_in[seen_ff[0]] = cur.data;
               end
               seen_in = seen_inc;
               if (seen_inc >= needed_ff) begin
                  res_fire  = 1'b1;
                  res_cp    = acc_shift;
                  needed_in = '0;
                  seen_in   = '0;
                  acc_in    = '0;
               end
            end else begin
               unique case (cur.kind)
                  KIND_PLAIN: begin
                     res_fire = 1'b1;
                     res_cp   = CP_W'(cur.data);
                  end
                  KIND_LEAD: begin
                     needed_in = cur.need;
                     seen_in   = '0;
                     acc_in    = lead_bits(cur.data, cur.need);
                  end
                  KIND_BAD: begin
                     res_fire = 1'b1;
                     res_cp   = REPLACEMENT_CP;
                     res_rep  = 1'b1;
                  end
                  KIND_END: begin
                  end
               endcase
            end
         end else if (needed_ff != '0) begin
            // string ends inside a sequence: replace the lead byte, replay the rest;
            // the end byte stays queued and is looked at again afterwards
            res_fire     = 1'b1;
            res_cp       = REPLACEMENT_CP;
            res_rep      = 1'b1;
            replay_in[0] = held_ff[0];
            replay_in[1] = held_ff[1];
            idx_in       = 1'b0;
            last_in      = seen_ff[1];
            needed_in    = '0;
            seen_in      = '0;
            acc_in       = '0;
            if (seen_ff != '0) begin
               state_in = ST_REPLAY;
            end
         end else begin
            pop          = 1'b1;
            rsp_valid_in = 1'b1;
            cp_in        = '0;
            rep_in       = 1'b0;
            gw_in        = '0;
            tw_in        = wsum_ff;
            eot_in       = 1'b1;
            wsum_in      = '0;
         end
      end

      gw       = (res_cp < NARROW_LIMIT) ? GW_NARROW : GW_WIDE;
      sum_wide = {1'b0, wsum_ff} + (TW_W + 1)'(gw);
      if (res_fire) begin
         wsum_in      = sum_wide[TW_W] ? WIDTH_MAX : sum_wide[TW_W-1:0];
         rsp_valid_in = 1'b1;
         cp_in        = res_cp;
         rep_in       = res_rep;
         gw_in        = gw;
         tw_in        = wsum_in;
         eot_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         needed_ff    <= '0;
         seen_ff      <= '0;
         acc_ff       <= '0;
         idx_ff       <= 1'b0;
         last_ff      <= 1'b0;
         wsum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         needed_ff    <= needed_in;
         seen_ff      <= seen_in;
         acc_ff       <= acc_in;
         idx_ff       <= idx_in;
         last_ff      <= last_in;
         wsum_ff      <= wsum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      held_ff   <= held_in;
      replay_ff <= replay_in;
      cp_ff     <= cp_in;
      rep_ff    <= rep_in;
      gw_ff     <= gw_in;
      tw_ff     <= tw_in;
      eot_ff    <= eot_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.code_point     = cp_ff;
   assign rsp_chan.is_replacement = rep_ff;
   assign rsp_chan.glyph_width    = gw_ff;
   assign rsp_chan.text_width     = tw_ff;
   assign rsp_chan.end_of_text    = eot_ff;

endmodule

FILE: rtl/lenient_utf8_decoder.sv
`timescale 1ns / 1ps
// lenient_utf8_decoder: top level, a classifying front end and a decoding back end.
// Depends on lud_pkg, lud_if, lud_front and lud_back.

// Decodes a zero-terminated UTF-8 byte stream leniently into one transaction per character:
// code point, replacement flag, glyph width (8 below 0x80, 16 otherwise) and the running,
// saturating text width. Following bytes are masked, never checked; bad lead bytes give
// 0xFFFD. A zero byte ending an open sequence gives 0xFFFD for the lead, the held bytes are
// decoded again, and the end transaction (end_of_text set, total width) follows. Ordinary
// bytes go at one per cycle while the result channel keeps taking results; each byte passes
// a queue slot and then the result register. A truncated end emits the replacement, replays
// each held byte and then gives the end transaction, the back end producing at most one result
// per cycle into its single result register while that register is free or being taken. The
// byte queue (QueueDepth entries) keeps input flowing while a result waits to be taken.
module lenient_utf8_decoder import lud_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   lud_req_if.sink  req_chan,
   lud_rsp_if.source rsp_chan
);

   queue_head_type head;
   logic           pop;

   // front end: handshake, classification, byte queue
   lud_front #(
      .Depth (QueueDepth)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .head     (head),
      .pop      (pop)
   );

   // back end: sequence assembly, replay, width sum, result register
   lud_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTHESIS
   // the end transaction carries nothing but the total width
   a_end_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.end_of_text |->
         rsp_chan.code_point == '0 && rsp_chan.glyph_width == '0 && !rsp_chan.is_replacement)
      else $error("end transaction carries a character");

   // glyph width follows the code point
   a_glyph: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.end_of_text |->
         rsp_chan.glyph_width == ((rsp_chan.code_point < NARROW_LIMIT) ? GW_NARROW : GW_WIDE))
      else $error("glyph width does not match code point");

   // a replacement always shows as U+FFFD
   a_repl: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.is_replacement |-> rsp_chan.code_point == REPLACEMENT_CP)
      else $error("replacement flag without U+FFFD");
`endif

endmodule

FILE: verif/lud_decode_checker.sv
`timescale 1ns / 1ps
// lud_decode_checker: watches both channels of the decoder, predicts each result and compares.
// Depends on lud_pkg and the lud_req_if / lud_rsp_if interfaces.
module lud_decode_checker import lud_pkg::*; (
   input  logic clock,
   input  logic reset,
   lud_req_if   req_mon,
   lud_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   glyphs_checked,
   output int   glyphs_pending
);

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            is_replacement;
      logic [GW_W-1:0] glyph_width;
      logic [TW_W-1:0] text_width;
      logic            end_of_text;
   } glyph_result_type;

   glyph_result_type expected_glyphs[$];

   // decoder state as the block should hold it
   logic [NEED_W-1:0] need_cnt;
   logic [NEED_W-1:0] seen_cnt;
   logic [CP_W-1:0]   acc;
   logic [BYTE_W-1:0] held [2];
   logic [TW_W-1:0]   width_sum;

   initial begin
      mismatch_count = 0;
      glyphs_checked = 0;
      glyphs_pending = 0;
   end

   function automatic void clear_sequence();
      need_cnt = '0;
      seen_cnt = '0;
      acc      = '0;
   endfunction

   function automatic void push_glyph(input logic [CP_W-1:0] cp, input logic rep);
      glyph_result_type g;
      logic [TW_W:0] sum;
      g.code_point     = cp;
      g.is_replacement = rep;
      g.glyph_width    = (cp < NARROW_LIMIT) ? GW_NARROW : GW_WIDE;
      sum              = {1'b0, width_sum} + (TW_W + 1)'(g.glyph_width);
      width_sum        = sum[TW_W] ? WIDTH_MAX : sum[TW_W-1:0];
      g.text_width     = width_sum;
      g.end_of_text    = 1'b0;
      expected_glyphs.push_back(g);
   endfunction

   // one nonzero byte into the decoder
   function automatic void decode_byte(input logic [BYTE_W-1:0] b);
      if (need_cnt != '0) begin
         acc = {acc[CP_W-CONT_BITS-1:0], b[CONT_BITS-1:0]};
         if (seen_cnt < 2) held[seen_cnt[0]] = b;
         seen_cnt = seen_cnt + 1'b1;
         if (seen_cnt >= need_cnt) begin
            push_glyph(acc, 1'b0);
            clear_sequence();
         end
      end else if (b < ASCII_LIMIT) begin
         push_glyph(CP_W'(b), 1'b0);
      end else if ((b & LEAD2_TOP) == LEAD2_CODE) begin
         need_cnt = 2'd1;
         seen_cnt = '0;
         acc      = CP_W'(b & LEAD2_BITS);
      end else if ((b & LEAD3_TOP) == LEAD3_CODE) begin
         need_cnt = 2'd2;
         seen_cnt = '0;
         acc      = CP_W'(b & LEAD3_BITS);
      end else if ((b & LEAD4_TOP) == LEAD4_CODE) begin
         need_cnt = 2'd3;
         seen_cnt = '0;
         acc      = CP_W'(b & LEAD4_BITS);
      end else begin
         push_glyph(REPLACEMENT_CP, 1'b1);
      end
   endfunction

   // zero byte: flush any open sequence (replaying its held bytes), then the end result
   function automatic void end_string();
      logic [BYTE_W-1:0] replay [2];
      int n;
      glyph_result_type g;
      while (need_cnt != '0) begin
         n = (seen_cnt > 2) ? 2 : int'(seen_cnt);
         replay = held;
         clear_sequence();
         push_glyph(REPLACEMENT_CP, 1'b1);
         for (int i = 0; i < n; i++) decode_byte(replay[i]);
      end
      g = '0;
      g.text_width  = width_sum;
      g.end_of_text = 1'b1;
      expected_glyphs.push_back(g);
      width_sum = '0;
      clear_sequence();
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_glyph();
      glyph_result_type exp;
      if (expected_glyphs.size() == 0) begin
         report_mismatch($sformatf("unexpected result cp=%h eot=%b",
                                   rsp_mon.code_point, rsp_mon.end_of_text));
         return;
      end
      exp = expected_glyphs.pop_front();
      glyphs_checked++;
      if (rsp_mon.code_point !== exp.code_point)
         report_mismatch($sformatf("code_point %h, want %h", rsp_mon.code_point,
                                   exp.code_point));
      if (rsp_mon.is_replacement !== exp.is_replacement)
         report_mismatch($sformatf("is_replacement %b, want %b (cp %h)",
                                   rsp_mon.is_replacement, exp.is_replacement,
                                   exp.code_point));
      if (rsp_mon.glyph_width !== exp.glyph_width)
         report_mismatch($sformatf("glyph_width %0d, want %0d (cp %h)",
                                   rsp_mon.glyph_width, exp.glyph_width, exp.code_point));
      if (rsp_mon.text_width !== exp.text_width)
         report_mismatch($sformatf("text_width %0d, want %0d (cp %h)",
                                   rsp_mon.text_width, exp.text_width, exp.code_point));
      if (rsp_mon.end_of_text !== exp.end_of_text)
         report_mismatch($sformatf("end_of_text %b, want %b (cp %h)",
                                   rsp_mon.end_of_text, exp.end_of_text, exp.code_point));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_sequence();
         width_sum = '0;
         expected_glyphs.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.in_byte == '0) end_string();
            else decode_byte(req_mon.in_byte);
         end
         if (rsp_mon.valid && rsp_mon.ready) check_glyph();
      end
      glyphs_pending = expected_glyphs.size();
   end

endmodule

FILE: verif/lenient_utf8_decoder_tb.sv
`timescale 1ns / 1ps
// lenient_utf8_decoder_tb: stimulus and verdict for the lenient UTF-8 decoder.
// Depends on lud_pkg, the channel interfaces, the decoder and lud_decode_checker.
module lenient_utf8_decoder_tb import lud_pkg::*; ;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   lud_req_if req_chan ();
   lud_rsp_if rsp_chan ();

   lenient_utf8_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   int mismatch_count;
   int glyphs_checked;
   int glyphs_pending;

   lud_decode_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .glyphs_checked (glyphs_checked),
      .glyphs_pending (glyphs_pending)
   );

   // idling rates in percent, and the length of a forced receiver hold-off
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_left    = 0;
   int bytes_sent    = 0;
   int strings_sent  = 0;

   // Directed bytes: ASCII extremes, every bad lead range, each sequence length at its
   // extremes (overlong forms and non-continuation bytes inside a sequence too), then
   // truncated ends, including the one whose replay re-opens a sequence twice over.
   logic [BYTE_W-1:0] directed_bytes[$] = '{
      8'h00,                                  // empty string
      8'h01, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF,
      8'hC0, 8'h80, 8'hDF, 8'hBF,             // overlong NUL, top of two-byte range
      8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF7, 8'hFF, 8'h41, 8'h01,
      8'h00,
      8'hC2, 8'h00,                           // lead with nothing after it
      8'hF0, 8'h41, 8'h42, 8'h00,             // replayed bytes come out as plain text
      8'hF0, 8'hF0, 8'hF0, 8'h00              // replay opens new sequences: four results
   };

   // Receiver: ready changes on the falling edge; a pending hold-off wins over the random rate.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // One transaction on the byte channel. Called on a falling edge, returns on one.
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
      if (b == '0) strings_sent++;
      @(negedge clock);
   endtask

   // mostly proper continuation bytes, now and then anything nonzero
   function automatic logic [BYTE_W-1:0] cont_byte();
      if ($urandom_range(7) == 0) return BYTE_W'($urandom_range(1, 255));
      return {2'b10, 6'($urandom_range(63))};
   endfunction

   function automatic logic [BYTE_W-1:0] lead_byte(input int need);
      case (need)
         1:       return {3'b110, 5'($urandom_range(31))};
         2:       return {4'b1110, 4'($urandom_range(15))};
         default: return {5'b11110, 3'($urandom_range(7))};
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] bad_lead();
      if ($urandom_range(1)) return BYTE_W'($urandom_range(8'h80, 8'hBF));
      return BYTE_W'($urandom_range(8'hF8, 8'hFF));
   endfunction

   // A string of random well-formed characters with bad leads and noise mixed in; now and
   // then it stops inside a sequence so that the end byte has to replay held bytes.
   task automatic send_random_string();
      int chars;
      int need;
      int kind;
      int cut;
      chars = $urandom_range(1, 10);
      for (int c = 0; c < chars; c++) begin
         kind = $urandom_range(11);
         if (kind <= 3) begin
            send_byte(BYTE_W'($urandom_range(1, 127)));
         end else if (kind <= 7) begin
            need = $urandom_range(1, 3);
            send_byte(lead_byte(need));
            for (int i = 0; i < need; i++) send_byte(cont_byte());
         end else if (kind == 8) begin
            send_byte(bad_lead());
         end else if (kind == 9) begin
            send_byte(BYTE_W'($urandom_range(1, 255)));
         end else if (kind == 10 && c == chars - 1) begin
            // truncated tail
            need = $urandom_range(1, 3);
            cut  = $urandom_range(0, need - 1);
            send_byte(lead_byte(need));
            for (int i = 0; i < cut; i++) send_byte(BYTE_W'($urandom_range(1, 255)));
         end else begin
            send_byte(BYTE_W'($urandom_range(1, 127)));
         end
      end
      send_byte('0);
   endtask

   task automatic run_random(input int target);
      while (bytes_sent < target) send_random_string();
   endtask

   // timeout
   initial begin
      #3ms;
      $display("status: fail");
      $finish;
   end

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.in_byte = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // phase 1: sender idles rarely, receiver often
      send_idle_pct = 7;
      recv_idle_pct = 60;
      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
      run_random(120);

      // phase 2: the other way round
      send_idle_pct = 60;
      recv_idle_pct = 7;
      run_random(210);

      // phase 3: no idling; a long hold-off first so the byte queue fills and ready drops
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_left    = 100;
      run_random(310);

      req_chan.valid <= 1'b0;

      // drain: every predicted transaction must turn up, then a short settle
      while (glyphs_pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d bytes in %0d strings; %0d results checked", bytes_sent,
               strings_sent, glyphs_checked);
      $display("incl. bad leads, overlong forms, truncated replays, back-pressure stalls");
      if (mismatch_count == 0 && glyphs_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
